// File: sv/opp_limit_snapper_core_assert.svh
// ----------------------------------------------------------------------------
// Operating-point limit snapper: assertion macros
// Shared wrappers for the concurrent checks on the core.
// ----------------------------------------------------------------------------
`ifndef OPP_LIMIT_SNAPPER_CORE_ASSERT_SVH
`define OPP_LIMIT_SNAPPER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the core clock and muted in reset.
`define OLS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("olsnap check failed");

// Next-cycle implication, sampled on the core clock and muted in reset.
`define OLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("olsnap check failed");

`endif

// File: sv/olsnap_pkg.sv
// ----------------------------------------------------------------------------
// Operating-point limit snapper package
// Widths, command codes, the comparator tree node and its merge function.
// ----------------------------------------------------------------------------
package olsnap_pkg;

  localparam int FREQ_W    = 40;
  localparam int CNT_W     = 4;
  localparam int IDX_W     = 3;
  // Number of slots a load item can address.
  localparam int MAX_SLOTS = 1 << IDX_W;

  typedef logic [FREQ_W-1:0] freq_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_SNAP = 1'b1
  } cmd_e;

  // One node of the comparator tree: the lowest live entry, the highest
  // entry at or below the ceiling and the lowest entry at or above the floor.
  typedef struct packed {
    logic  lo_vld;
    freq_t lo;
    logic  le_vld;
    freq_t le;
    logic  ge_vld;
    freq_t ge;
  } node_t;

  // Request data that rides alongside the tree.
  typedef struct packed {
    logic  applied;
    freq_t req_min;
    freq_t req_max;
  } side_t;

  // Combine two subtrees into one node.
  function automatic node_t olsnap_merge(node_t a, node_t b);
    node_t r;
    r.lo_vld = a.lo_vld | b.lo_vld;
    r.lo     = (a.lo_vld && (!b.lo_vld || (a.lo <= b.lo))) ? a.lo : b.lo;
    r.le_vld = a.le_vld | b.le_vld;
    r.le     = (a.le_vld && (!b.le_vld || (a.le >= b.le))) ? a.le : b.le;
    r.ge_vld = a.ge_vld | b.ge_vld;
    r.ge     = (a.ge_vld && (!b.ge_vld || (a.ge <= b.ge))) ? a.ge : b.ge;
    return r;
  endfunction

endpackage

// File: sv/olsnap_table.sv
// ----------------------------------------------------------------------------
// Operating-point table
// Stores the loadable frequency entries; an entry never written reads zero.
// ----------------------------------------------------------------------------
module olsnap_table import olsnap_pkg::*; #(
  parameter int  OPP_POINTS = 8,
  localparam int STORED     = (OPP_POINTS < MAX_SLOTS) ? OPP_POINTS : MAX_SLOTS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_idx_i,
  input  freq_t            wr_data_i,
  output freq_t            entries_o [STORED]
);

  logic [STORED-1:0] vld_q;
  freq_t             data_q [STORED];

  // Valid bits stand in for clearing the table at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < STORED; k++) begin
        if (wr_en_i && (32'(wr_idx_i) == k)) begin
          vld_q[k] <= 1'b1;
        end
      end
    end
  end

  // Entry data; a load to a slot beyond the table matches no entry.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < STORED; k++) begin
      if (wr_en_i && (32'(wr_idx_i) == k)) begin
        data_q[k] <= wr_data_i;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < STORED; k++) begin
      entries_o[k] = vld_q[k] ? data_q[k] : '0;
    end
  end

endmodule

// File: sv/olsnap_tree.sv
// ----------------------------------------------------------------------------
// Comparator tree
// Captures one leaf per entry, then reduces pairs one level per stage.
// ----------------------------------------------------------------------------
module olsnap_tree import olsnap_pkg::*; #(
  parameter int  OPP_POINTS = 8,
  localparam int STORED     = (OPP_POINTS < MAX_SLOTS) ? OPP_POINTS : MAX_SLOTS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  freq_t entries_i [STORED],
  input  cnt_t  count_i,
  input  freq_t req_min_i,
  input  freq_t req_max_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output node_t root_o,
  output side_t side_o
);

  // Slots above the loadable ones are always zero, so they act as one
  // zero-valued leaf that is live whenever the count reaches past them.
  localparam int HAS_ZERO = (OPP_POINTS > MAX_SLOTS) ? 1 : 0;
  localparam int NCAND    = STORED + HAS_ZERO;
  localparam int LEVELS   = $clog2(NCAND);
  localparam int LEAVES   = 1 << LEVELS;

  cnt_t            n_sat;
  node_t           leaf_d [LEAVES];
  node_t           heap_q [1:2*LEAVES-1];
  side_t           side_q [LEVELS+1];
  logic [LEVELS:0] vld_q;
  logic [LEVELS+1:0] rdy;

  // Counts beyond the table saturate to its size.
  assign n_sat = (32'(count_i) > OPP_POINTS) ? CNT_W'(OPP_POINTS) : count_i;

  // Leaf nodes with their threshold compares.
  for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
    if (k < STORED) begin : g_entry
      logic live;
      assign live = (32'(n_sat) > k);
      always_comb begin
        leaf_d[k].lo_vld = live;
        leaf_d[k].lo     = entries_i[k];
        leaf_d[k].le_vld = live && (entries_i[k] <= req_max_i);
        leaf_d[k].le     = entries_i[k];
        leaf_d[k].ge_vld = live && (entries_i[k] >= req_min_i);
        leaf_d[k].ge     = entries_i[k];
      end
    end else if ((HAS_ZERO == 1) && (k == STORED)) begin : g_zero
      logic live;
      assign live = (32'(n_sat) > STORED);
      always_comb begin
        leaf_d[k].lo_vld = live;
        leaf_d[k].lo     = '0;
        leaf_d[k].le_vld = live;
        leaf_d[k].le     = '0;
        leaf_d[k].ge_vld = live && (req_min_i == '0);
        leaf_d[k].ge     = '0;
      end
    end else begin : g_pad
      assign leaf_d[k] = '0;
    end
  end

  // Backpressure: a stage takes new data when empty or when it drains.
  assign rdy[LEVELS+1] = out_ready_i;
  for (genvar s = 0; s <= LEVELS; s++) begin : g_rdy
    assign rdy[s] = !vld_q[s] || rdy[s+1];
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int s = 1; s <= LEVELS; s++) begin
        if (rdy[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  // Request data travelling with each stage.
  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      side_q[0].applied <= (n_sat != '0);
      side_q[0].req_min <= req_min_i;
      side_q[0].req_max <= req_max_i;
    end
    for (int s = 1; s <= LEVELS; s++) begin
      if (rdy[s] && vld_q[s-1]) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // Tree nodes in heap order; node i sits in the stage of its depth.
  for (genvar i = 1; i < 2*LEAVES; i++) begin : g_node
    localparam int ST = LEVELS - ($clog2(i + 1) - 1);
    if (i >= LEAVES) begin : g_cap
      always_ff @(posedge clk_i) begin
        if (rdy[0] && in_valid_i) begin
          heap_q[i] <= leaf_d[i-LEAVES];
        end
      end
    end else begin : g_red
      always_ff @(posedge clk_i) begin
        if (rdy[ST] && vld_q[ST-1]) begin
          heap_q[i] <= olsnap_merge(heap_q[2*i], heap_q[2*i+1]);
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[LEVELS];
  assign root_o      = heap_q[1];
  assign side_o      = side_q[LEVELS];

endmodule

// File: sv/olsnap_fixup.sv
// ----------------------------------------------------------------------------
// Snap resolution and output register
// Turns the tree root into the snapped limits and flags, then holds the item.
// ----------------------------------------------------------------------------
module olsnap_fixup import olsnap_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  node_t root_i,
  input  side_t side_i,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output freq_t snap_floor_o,
  output freq_t snap_ceil_o,
  output logic  applied_o,
  output logic  ceiling_raised_o,
  output logic  floor_relaxed_o
);

  freq_t smax, smin;
  logic  raised, relaxed, force_floor;
  logic  vld_q;
  freq_t smin_q, smax_q;
  logic  applied_q, raised_q, relaxed_q;

  // With no entry under the ceiling the lowest entry is used; a floor not met
  // at or below the ceiling collapses onto it. Unapplied requests pass through.
  always_comb begin
    smax        = root_i.le_vld ? root_i.le : root_i.lo;
    force_floor = !root_i.ge_vld || (root_i.ge > smax);
    smin        = force_floor ? smax : root_i.ge;
    raised      = !root_i.le_vld;
    relaxed     = force_floor && (smax < side_i.req_min);
    if (!side_i.applied) begin
      smin    = side_i.req_min;
      smax    = side_i.req_max;
      raised  = 1'b0;
      relaxed = 1'b0;
    end
  end

  assign in_ready_o = !vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  // Result item register.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      smin_q    <= smin;
      smax_q    <= smax;
      applied_q <= side_i.applied;
      raised_q  <= raised;
      relaxed_q <= relaxed;
    end
  end

  assign out_valid_o      = vld_q;
  assign snap_floor_o     = smin_q;
  assign snap_ceil_o      = smax_q;
  assign applied_o        = applied_q;
  assign ceiling_raised_o = raised_q;
  assign floor_relaxed_o  = relaxed_q;

endmodule

// File: sv/opp_limit_snapper_core.sv
// One item is accepted per clock cycle while in_stall_o is low, loads and
// snap queries alike. A load item writes its table slot at once and is seen
// by the very next query; it gives no result. A snap query passes through a
// registered comparator tree of depth LEVELS: the base-two logarithm, rounded
// up, of its leaf count, which is min(OPP_POINTS, 8) plus one shared zero
// leaf when OPP_POINTS exceeds 8. The stages are the leaf capture with its
// threshold compares, one stage per tree level and the output register,
// which is fed by the resolution logic. Stall on the output backs up
// through the stages without losing an item, and the input stalls only once
// every stage holds an item. The table is cleared at reset through per-slot
// valid bits, so no clearing pass is needed. Write entry_count only while no
// query is in flight.
// ----------------------------------------------------------------------------
// Operating-point limit snapper core
// Snaps a requested frequency floor and ceiling to a loadable table.
// ----------------------------------------------------------------------------
module opp_limit_snapper_core import olsnap_pkg::*; #(
  parameter int OPP_POINTS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_wr_en_i,
  input  logic [CNT_W-1:0] cfg_wr_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  input  logic [IDX_W-1:0] entry_index_i,
  input  logic [FREQ_W-1:0] entry_freq_i,
  input  logic [FREQ_W-1:0] req_floor_i,
  input  logic [FREQ_W-1:0] requested_max_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [FREQ_W-1:0] snap_floor_o,
  output logic [FREQ_W-1:0] snap_ceil_o,
  output logic             applied_o,
  output logic             ceiling_raised_o,
  output logic             floor_relaxed_o
);

  localparam int STORED = (OPP_POINTS < MAX_SLOTS) ? OPP_POINTS : MAX_SLOTS;

  cnt_t  count_q;
  freq_t entries [STORED];
  logic  tree_ready, load_en, query_vld;
  logic  root_vld, fix_ready;
  node_t root;
  side_t side;

  // Entry-count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_wr_en_i) begin
      count_q <= cfg_wr_data_i;
    end
  end

  // Steer the input item: loads go to the table, queries into the tree.
  assign in_stall_o = !tree_ready;
  assign load_en    = in_valid_i && !in_stall_o && (cmd_i == CMD_LOAD);
  assign query_vld  = in_valid_i && (cmd_i == CMD_SNAP);

  olsnap_table #(
    .OPP_POINTS (OPP_POINTS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (load_en),
    .wr_idx_i  (entry_index_i),
    .wr_data_i (entry_freq_i),
    .entries_o (entries)
  );

  olsnap_tree #(
    .OPP_POINTS (OPP_POINTS)
  ) u_tree (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (query_vld),
    .in_ready_o  (tree_ready),
    .entries_i   (entries),
    .count_i     (count_q),
    .req_min_i   (req_floor_i),
    .req_max_i   (requested_max_i),
    .out_valid_o (root_vld),
    .out_ready_i (fix_ready),
    .root_o      (root),
    .side_o      (side)
  );

  olsnap_fixup u_fixup (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (root_vld),
    .in_ready_o       (fix_ready),
    .root_i           (root),
    .side_i           (side),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .snap_floor_o     (snap_floor_o),
    .snap_ceil_o      (snap_ceil_o),
    .applied_o        (applied_o),
    .ceiling_raised_o (ceiling_raised_o),
    .floor_relaxed_o  (floor_relaxed_o)
  );

endmodule

// File: sv/olsnap_checker.sv
// ----------------------------------------------------------------------------
// Operating-point limit snapper checker
// Port-level checks on result items, bound to the core.
// ----------------------------------------------------------------------------
`include "opp_limit_snapper_core_assert.svh"

module olsnap_checker import olsnap_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [FREQ_W-1:0] snap_floor_o,
  input logic [FREQ_W-1:0] snap_ceil_o,
  input logic              applied_o,
  input logic              ceiling_raised_o,
  input logic              floor_relaxed_o
);

  // A stalled result item stays put.
  `OLS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(snap_floor_o) && $stable(snap_ceil_o))

  // A pass-through item carries no flags.
  `OLS_ASSERT_NOW(a_pass_flags, out_valid_o && !applied_o, !ceiling_raised_o && !floor_relaxed_o)

  // A snapped floor never lies above the snapped ceiling.
  `OLS_ASSERT_NOW(a_order, out_valid_o && applied_o, snap_floor_o <= snap_ceil_o)

  // A relaxed floor has collapsed onto the ceiling.
  `OLS_ASSERT_NOW(a_relaxed, out_valid_o && floor_relaxed_o, snap_floor_o == snap_ceil_o)

  // Raising the ceiling only happens when the table was used.
  `OLS_ASSERT_NOW(a_raised, out_valid_o && ceiling_raised_o, applied_o)

endmodule

bind opp_limit_snapper_core olsnap_checker u_olsnap_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .snap_floor_o     (snap_floor_o),
  .snap_ceil_o      (snap_ceil_o),
  .applied_o        (applied_o),
  .ceiling_raised_o (ceiling_raised_o),
  .floor_relaxed_o  (floor_relaxed_o)
);

// File: tb/opp_limit_snapper_checker.sv
// ----------------------------------------------------------------------------
// Operating-point limit snapper checker
// Watches the load/query and result channels and the entry-count write port,
// keeps its own copy of the frequency table, predicts each snap result and
// compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module opp_limit_snapper_checker import olsnap_pkg::*; #(
  parameter int OPP_POINTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wr_en_i,
  input  logic [CNT_W-1:0]  cfg_wr_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              cmd_i,
  input  logic [IDX_W-1:0]  entry_index_i,
  input  logic [FREQ_W-1:0] entry_freq_i,
  input  logic [FREQ_W-1:0] req_floor_i,
  input  logic [FREQ_W-1:0] requested_max_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [FREQ_W-1:0] snap_floor_i,
  input  logic [FREQ_W-1:0] snap_ceil_i,
  input  logic              applied_i,
  input  logic              ceiling_raised_i,
  input  logic              floor_relaxed_i,
  output int                pending_o,
  output int                fail_count_o
);

  // One predicted snap result.
  typedef struct packed {
    freq_t snap_floor;
    freq_t snap_ceil;
    logic  applied;
    logic  ceiling_raised;
    logic  floor_relaxed;
  } snap_res_t;

  freq_t     opp_table [OPP_POINTS];
  cnt_t      entry_count;
  snap_res_t snap_results_q[$];
  snap_res_t oldest;
  int        mismatches;

  // Snap a floor and ceiling request to the live part of the table.
  function automatic snap_res_t snap_request(freq_t req_min, freq_t req_max);
    snap_res_t r;
    int        live;
    freq_t     lowest;
    freq_t     ceil_f;
    freq_t     floor_f;
    logic      got_ceil;
    logic      got_floor;
    r         = '0;
    live      = (int'(entry_count) > OPP_POINTS) ? OPP_POINTS : int'(entry_count);
    got_ceil  = 1'b0;
    got_floor = 1'b0;
    ceil_f    = '0;
    floor_f   = '0;
    // An empty table hands the request back untouched.
    if (live == 0) begin
      r.snap_floor = req_min;
      r.snap_ceil  = req_max;
      return r;
    end
    lowest = opp_table[0];
    for (int i = 0; i < live; i++) begin
      if (opp_table[i] < lowest) begin
        lowest = opp_table[i];
      end
      if (opp_table[i] <= req_max && (!got_ceil || opp_table[i] > ceil_f)) begin
        ceil_f   = opp_table[i];
        got_ceil = 1'b1;
      end
      if (opp_table[i] >= req_min && (!got_floor || opp_table[i] < floor_f)) begin
        floor_f   = opp_table[i];
        got_floor = 1'b1;
      end
    end
    // Nothing fits under the ceiling, so it is lifted to the lowest entry.
    if (!got_ceil) begin
      ceil_f           = lowest;
      r.ceiling_raised = 1'b1;
    end
    // The floor cannot be met at or below the ceiling, so it follows it.
    if (!got_floor || floor_f > ceil_f) begin
      floor_f         = ceil_f;
      r.floor_relaxed = (ceil_f < req_min);
    end
    r.snap_floor = floor_f;
    r.snap_ceil  = ceil_f;
    r.applied    = 1'b1;
    return r;
  endfunction

  task automatic check_field(string field, freq_t want, freq_t got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endtask

  // Results are checked before the same edge's input is taken in, so a
  // result can never be matched against a query accepted alongside it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (opp_table[i]) begin
        opp_table[i] = '0;
      end
      entry_count = '0;
      snap_results_q.delete();
      mismatches   = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (snap_results_q.size() == 0) begin
          $error("result item arrived with no snap query outstanding");
          mismatches++;
        end else begin
          oldest = snap_results_q.pop_front();
          check_field("snap_floor", oldest.snap_floor, snap_floor_i);
          check_field("snap_ceil", oldest.snap_ceil, snap_ceil_i);
          check_field("applied", freq_t'(oldest.applied), freq_t'(applied_i));
          check_field("ceiling_raised", freq_t'(oldest.ceiling_raised),
                      freq_t'(ceiling_raised_i));
          check_field("floor_relaxed", freq_t'(oldest.floor_relaxed),
                      freq_t'(floor_relaxed_i));
        end
      end
      if (cfg_wr_en_i) begin
        entry_count = cfg_wr_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        if (cmd_i == CMD_LOAD) begin
          if (int'(entry_index_i) < OPP_POINTS) begin
            opp_table[entry_index_i] = entry_freq_i;
          end
        end else begin
          snap_results_q.push_back(snap_request(req_floor_i, requested_max_i));
        end
      end
      pending_o    <= snap_results_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// File: tb/tb_opp_limit_snapper_core.sv
// ----------------------------------------------------------------------------
// Operating-point limit snapper testbench
// Loads frequency tables, sweeps the entry count through empty, partial, full
// and saturated settings, and fires snap queries at the core under bursty
// input and patterned output stalls; the checker predicts every result.
// ----------------------------------------------------------------------------
module tb_opp_limit_snapper_core;
  import olsnap_pkg::*;

  localparam int    OPP_POINTS     = 8;
  localparam int    CLK_PERIOD     = 12;
  localparam int    DRAIN_CYCLES   = 10;
  localparam int    LONG_HOLD      = 150;
  localparam int    RAND_ITEMS     = 1150;
  localparam int    TIMEOUT_CYCLES = 400000;
  localparam freq_t FREQ_MAX       = '1;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_wr_en;
  cnt_t              cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic              cmd;
  logic [IDX_W-1:0]  entry_index;
  freq_t             entry_freq;
  freq_t             req_floor;
  freq_t             requested_max;
  logic              out_valid;
  logic              out_stall;
  freq_t             snap_floor;
  freq_t             snap_ceil;
  logic              applied;
  logic              ceiling_raised;
  logic              floor_relaxed;
  int                pending;
  int                fail_count;

  // Frequencies loaded so far, used to aim queries at table values.
  freq_t shadow [MAX_SLOTS];
  int    burst_left;
  bit    hold_req;
  bit    hold_done;

  opp_limit_snapper_core #(
    .OPP_POINTS(OPP_POINTS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cmd_i           (cmd),
    .entry_index_i   (entry_index),
    .entry_freq_i    (entry_freq),
    .req_floor_i     (req_floor),
    .requested_max_i (requested_max),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .snap_floor_o    (snap_floor),
    .snap_ceil_o     (snap_ceil),
    .applied_o       (applied),
    .ceiling_raised_o(ceiling_raised),
    .floor_relaxed_o (floor_relaxed)
  );

  opp_limit_snapper_checker #(
    .OPP_POINTS(OPP_POINTS)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en),
    .cfg_wr_data_i   (cfg_wr_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .cmd_i           (cmd),
    .entry_index_i   (entry_index),
    .entry_freq_i    (entry_freq),
    .req_floor_i     (req_floor),
    .requested_max_i (requested_max),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .snap_floor_i    (snap_floor),
    .snap_ceil_i     (snap_ceil),
    .applied_i       (applied),
    .ceiling_raised_i(ceiling_raised),
    .floor_relaxed_i (floor_relaxed),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  // Clock generation.
  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // Frequency picker: edges of the range, table hits and near misses, round
  // numbers that tend to collide, and fully random values.
  function automatic freq_t rand_freq();
    freq_t f;
    case ($urandom_range(0, 11))
      0:       f = '0;
      1:       f = FREQ_MAX;
      2, 3, 4: f = shadow[IDX_W'($urandom_range(0, MAX_SLOTS - 1))];
      5:       f = shadow[IDX_W'($urandom_range(0, MAX_SLOTS - 1))] + freq_t'(1);
      6:       f = shadow[IDX_W'($urandom_range(0, MAX_SLOTS - 1))] - freq_t'(1);
      7, 8:    f = freq_t'($urandom_range(1, 64) * 1000);
      default: f = freq_t'({$urandom(), $urandom()});
    endcase
    return f;
  endfunction

  // Entry counts weighted towards empty, single, full and saturated tables.
  function automatic cnt_t pick_count();
    case ($urandom_range(0, 9))
      0:       return cnt_t'(0);
      1:       return cnt_t'(1);
      2:       return cnt_t'(OPP_POINTS);
      3:       return cnt_t'($urandom_range(OPP_POINTS + 1, (1 << CNT_W) - 1));
      default: return cnt_t'($urandom_range(1, OPP_POINTS));
    endcase
  endfunction

  // Offer one item, opening a new burst after a random gap when the current
  // burst is used up, and hold it until the core takes it.
  task automatic offer(cmd_e op, logic [IDX_W-1:0] idx, freq_t f, freq_t mn, freq_t mx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    cmd           <= op;
    entry_index   <= idx;
    entry_freq    <= f;
    req_floor     <= mn;
    requested_max <= mx;
    do @(posedge clk_i); while (in_stall);
    if (op == CMD_LOAD) begin
      shadow[idx] = f;
    end
  endtask

  task automatic load_slot(int idx, freq_t f);
    offer(CMD_LOAD, idx[IDX_W-1:0], f, rand_freq(), rand_freq());
  endtask

  task automatic snap(freq_t mn, freq_t mx);
    offer(CMD_SNAP, IDX_W'($urandom_range(0, MAX_SLOTS - 1)), rand_freq(), mn, mx);
  endtask

  // Stop offering until every snap result is back and the pipeline is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // The entry count is only changed with nothing in flight.
  task automatic write_count(cnt_t value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk_i);
    cfg_wr_en   <= 1'b0;
  endtask

  // Result side: free-running, random, periodic and held stretches, plus
  // one long hold-off on request so the core backs up into its input.
  initial begin
    int mode;
    int span;
    int period;
    out_stall <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 9);
        span = $urandom_range(4, 40);
        case (mode)
          0, 1, 2: begin
            out_stall <= 1'b0;
            repeat (span) @(posedge clk_i);
          end
          3, 4, 5: begin
            repeat (span) begin
              out_stall <= ($urandom_range(0, 99) < 40);
              @(posedge clk_i);
            end
          end
          6, 7: begin
            period = $urandom_range(2, 5);
            for (int i = 0; i < span; i++) begin
              out_stall <= (i % period == 0);
              @(posedge clk_i);
            end
          end
          8: begin
            repeat (span) begin
              out_stall <= ($urandom_range(0, 99) < 85);
              @(posedge clk_i);
            end
          end
          default: begin
            out_stall <= 1'b1;
            repeat ($urandom_range(8, 30)) @(posedge clk_i);
          end
        endcase
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int    sent;
    int    phase_len;
    freq_t lo_f;
    freq_t hi_f;
    rst_ni        <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_valid      <= 1'b0;
    cmd           <= CMD_LOAD;
    entry_index   <= '0;
    entry_freq    <= '0;
    req_floor     <= '0;
    requested_max <= '0;
    foreach (shadow[i]) begin
      shadow[i] = '0;
    end
    burst_left = 0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table after reset: requests pass straight through.
    snap('0, FREQ_MAX);
    snap(FREQ_MAX, '0);

    // Full count over the cleared table: every entry reads as zero.
    write_count(cnt_t'(OPP_POINTS));
    snap(freq_t'(5), freq_t'(10));
    snap('0, '0);

    // A table with a duplicate, the top frequency and no zero entry.
    load_slot(0, FREQ_MAX);
    load_slot(1, freq_t'(5000));
    load_slot(2, freq_t'(1000));
    load_slot(3, freq_t'(3000));
    load_slot(4, freq_t'(3000));
    load_slot(5, freq_t'(7000));
    load_slot(6, freq_t'(2000));
    load_slot(7, freq_t'(9000));
    snap('0, FREQ_MAX);
    snap(freq_t'(2500), freq_t'(6000));
    snap(freq_t'(3000), freq_t'(3000));
    // Ceiling below every entry, alone and with an unreachable floor.
    snap('0, freq_t'(500));
    snap(freq_t'(8000), freq_t'(500));
    // Floor above the snapped ceiling, and the floor at the very top.
    snap(freq_t'(6000), freq_t'(4000));
    snap(FREQ_MAX, FREQ_MAX);
    snap(FREQ_MAX, FREQ_MAX - freq_t'(1));

    // Partial, saturated and single-entry counts over the same table.
    write_count(cnt_t'(3));
    snap(freq_t'(2000), freq_t'(4000));
    write_count('1);
    snap(freq_t'(2500), freq_t'(6000));
    write_count(cnt_t'(1));
    snap('0, '0);

    // Random phases, each under a fresh entry count; the first one is long
    // and carries the receiver's long hold-off.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      write_count(pick_count());
      if (sent == 0) begin
        phase_len = 160;
        hold_req  = 1'b1;
      end else begin
        phase_len = $urandom_range(20, 120);
      end
      repeat (phase_len) begin
        if ($urandom_range(0, 3) == 0) begin
          load_slot($urandom_range(0, MAX_SLOTS - 1), rand_freq());
        end else begin
          lo_f = rand_freq();
          hi_f = rand_freq();
          // Mostly well-ordered requests, with some inverted ones kept.
          if (lo_f > hi_f && $urandom_range(0, 3) != 0) begin
            snap(hi_f, lo_f);
          end else begin
            snap(lo_f, hi_f);
          end
        end
      end
      sent += phase_len;
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("TB_ERROR");
    $finish;
  end

endmodule
